>>> rtl/deadline_slot_scheduler_with_backoff_top_assert.svh
// assertion macros for the slot scheduler top level
// no dependencies; bodies vanish when SYNTHESIS is defined
`ifndef DEADLINE_SLOT_SCHEDULER_WITH_BACKOFF_TOP_ASSERT_SVH
`define DEADLINE_SLOT_SCHEDULER_WITH_BACKOFF_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define DSS_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define DSS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define DSS_ASSERT_IMPL(label, ante, cons)
`define DSS_ASSERT_NEXT(label, ante, cons)
`endif
`endif

>>> rtl/dss_pkg.sv
// shared types and constants of the slot scheduler
// no dependencies
`timescale 1ns / 1ps
package dss_pkg;
    localparam int SLOTS = 8;
    localparam int SLOT_W = 3;
    localparam int RANK_W = 4;
    localparam logic [31:0] GRID_LEAD_MS = 32'd2000;
    localparam logic [31:0] RETRY_CAP_S = 32'd3600;
    localparam logic [9:0] MS_PER_S = 10'd1000;
    localparam logic [3:0] RANK_MAX = 4'd15;

    localparam logic [1:0] FUNC_TICK = 2'd0;
    localparam logic [1:0] FUNC_UPDATE = 2'd1;
    localparam logic [1:0] FUNC_DONE = 2'd2;

    localparam logic [2:0] ERR_OK = 3'd0;
    localparam logic [2:0] ERR_AUTH = 3'd1;
    localparam logic [2:0] ERR_RELOGIN = 3'd2;
    localparam logic [2:0] ERR_REFRESH = 3'd3;
    localparam logic [2:0] ERR_PARSER = 3'd4;
    localparam logic [2:0] ERR_NOCONF = 3'd5;
    localparam logic [2:0] ERR_RATE = 3'd6;

    localparam logic [2:0] REG_PERIOD = 3'd0;
    localparam logic [2:0] REG_AUTH = 3'd1;
    localparam logic [2:0] REG_REFRESH = 3'd2;
    localparam logic [2:0] REG_PARSER = 3'd3;
    localparam logic [2:0] REG_BOFFMAX = 3'd4;

    typedef struct packed {
        logic [1:0]  func;
        logic [2:0]  slot;
        logic [31:0] now_ms;
        logic [31:0] slot_identity;
        logic        now_active;
        logic [3:0]  active_total;
        logic [2:0]  error_code;
        logic [15:0] failures;
        logic [31:0] retry_after_s;
    } cmd_t;

    typedef struct packed {
        logic        picked;
        logic [2:0]  picked_slot;
        logic [30:0] lateness_ms;
        logic        clear_usage;
        logic        clear_token;
        logic        discarded;
        logic [31:0] next_due_ms;
    } result_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_SCAN, ST_SCAN_LAST, ST_READ, ST_DIV, ST_MUL,
        ST_DBL, ST_RETRY, ST_WRITE, ST_DONE
    } state_t;
endpackage

>>> rtl/deadline_slot_scheduler_with_backoff_top.sv
// slot scheduler top level: fsm, slot memory, serial divider and doubler
// depends on dss_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "deadline_slot_scheduler_with_backoff_top_assert.svh"
//
//  channel   signals                          direction  transfer
//  command   start, busy, cmd                 in         start && !busy
//  result    done, result                     out        done (one cycle)
//  config    cfg_we, cfg_index, cfg_data      in         cfg_we
//
// tick: one memory read per slot
// update: read and write back; a new grid slot adds a restoring divide
//   of period by active_total and one multiply
// completion: read and write back; doubling codes add doubling steps
//   and a retry-after step; an unknown kind goes straight to done
// reset clears slot memory valid bits, rank and control registers and loads config defaults at once
// results cannot be stalled; done is a single-cycle strobe
module deadline_slot_scheduler_with_backoff_top
    import dss_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  cmd_t        cmd,
    output logic        done,
    output result_t     result,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    // configuration registers
    logic [31:0] period_reg, auth_reg, refresh_reg, parser_reg, boffmax_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg  <= 32'd300000;
            auth_reg    <= 32'd3600000;
            refresh_reg <= 32'd600000;
            parser_reg  <= 32'd300000;
            boffmax_reg <= 32'd3600000;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_PERIOD:  period_reg  <= cfg_data;
                REG_AUTH:    auth_reg    <= cfg_data;
                REG_REFRESH: refresh_reg <= cfg_data;
                REG_PARSER:  parser_reg  <= cfg_data;
                REG_BOFFMAX: boffmax_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // slot memory: due time, active, identity; valid bits give reset zero
    logic [64:0] mem [SLOTS];
    logic [SLOTS-1:0] vld_reg;
    logic [SLOT_W-1:0] rd_addr;
    logic [64:0] rd_raw_reg;
    logic rd_vld_reg;
    logic mem_we;
    logic [SLOT_W-1:0] wr_addr;
    logic [64:0] wr_data;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[wr_addr] <= wr_data;
        rd_raw_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (mem_we)
                vld_reg[wr_addr] <= 1'b1;
            rd_vld_reg <= vld_reg[rd_addr];
        end
    end

    logic [64:0] rd_data;
    assign rd_data = rd_vld_reg ? rd_raw_reg : 65'd0;
    logic [31:0] rd_due, rd_ident;
    logic rd_act;
    assign rd_due = rd_data[64:33];
    assign rd_act = rd_data[32];
    assign rd_ident = rd_data[31:0];

    // control and datapath registers
    state_t state_reg, state_next;
    cmd_t cmd_reg;
    logic [SLOT_W:0] cnt_reg, cnt_next;
    logic [RANK_W-1:0] rank_reg, rank_next;
    logic found_reg, found_next;
    logic [SLOT_W-1:0] best_reg, best_next;
    logic [31:0] late_reg, late_next;
    logic [31:0] due_reg, due_next;
    logic act_reg, act_next;
    logic [31:0] idn_reg, idn_next;
    logic [31:0] quo_reg, quo_next;
    logic [32:0] rem_reg, rem_next;
    logic [32:0] wait_reg, wait_next;
    logic [15:0] fcnt_reg, fcnt_next;
    logic [4:0] rank_use_reg, rank_use_next;
    result_t res_reg, res_next;
    logic done_reg, done_next;

    // scan candidate
    logic [31:0] scan_late;
    logic scan_take;
    assign scan_late = cmd_reg.now_ms - rd_due;
    assign scan_take = rd_act && !scan_late[31] && (!found_reg || scan_late > late_reg);

    logic [SLOT_W-1:0] cnt_idx;
    assign cnt_idx = cnt_reg[SLOT_W-1:0];

    logic [32:0] div_trial;
    assign div_trial = {rem_reg[31:0], quo_reg[31]} - {29'd0, cmd_reg.active_total};

    logic [31:0] retry_ms;
    logic [31:0] retry_s_cap;
    assign retry_s_cap = (cmd_reg.retry_after_s < RETRY_CAP_S) ? cmd_reg.retry_after_s
                                                               : RETRY_CAP_S;
    assign retry_ms = retry_s_cap[11:0] * {22'd0, MS_PER_S};

    logic [31:0] grid_off;
    assign grid_off = quo_reg * {28'd0, rank_use_reg[3:0]};

    logic [31:0] ok_due;
    logic [31:0] ok_diff;
    assign ok_due = due_reg + period_reg;
    assign ok_diff = cmd_reg.now_ms - ok_due;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (start)
                begin
                    if (cmd.func == FUNC_TICK)
                        state_next = ST_SCAN;
                    else if (cmd.func == FUNC_UPDATE || cmd.func == FUNC_DONE)
                        state_next = ST_READ;
                    else
                        state_next = ST_DONE;
                end
            ST_SCAN:
                if (cnt_reg == SLOT_W'(SLOTS - 1) + (SLOT_W + 1)'(0))
                    state_next = ST_SCAN_LAST;
            ST_SCAN_LAST: state_next = ST_DONE;
            ST_READ:
                if (cmd_reg.func == FUNC_UPDATE)
                    state_next = (cmd_reg.now_active && (!rd_act ||
                                  cmd_reg.slot_identity != rd_ident)) ? ST_DIV : ST_WRITE;
                else if (cmd_reg.slot_identity != rd_ident || cmd_reg.error_code == ERR_OK
                         || cmd_reg.error_code < ERR_RATE)
                    state_next = ST_WRITE;
                else
                    state_next = ST_DBL;
            ST_DIV:
                if (cnt_reg == (SLOT_W + 1)'(0) && fcnt_reg == 16'd0)
                    state_next = ST_MUL;
            ST_MUL: state_next = ST_WRITE;
            ST_DBL:
                if (!(fcnt_reg > 16'd1 && wait_reg < {1'b0, boffmax_reg} && wait_reg != 33'd0))
                    state_next = ST_RETRY;
            ST_RETRY: state_next = ST_WRITE;
            ST_WRITE: state_next = ST_DONE;
            ST_DONE: state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath
    always_comb
    begin
        cnt_next = cnt_reg;
        rank_next = rank_reg;
        found_next = found_reg;
        best_next = best_reg;
        late_next = late_reg;
        due_next = due_reg;
        act_next = act_reg;
        idn_next = idn_reg;
        quo_next = quo_reg;
        rem_next = rem_reg;
        wait_next = wait_reg;
        fcnt_next = fcnt_reg;
        rank_use_next = rank_use_reg;
        res_next = res_reg;
        done_next = 1'b0;
        rd_addr = cmd_reg.slot;
        mem_we = 1'b0;
        wr_addr = cmd_reg.slot;
        wr_data = {due_reg, act_reg, idn_reg};
        case (state_reg)
            ST_IDLE:
            begin
                rd_addr = (cmd.func == FUNC_TICK) ? '0 : cmd.slot;
                cnt_next = (SLOT_W + 1)'(1);
                found_next = 1'b0;
                late_next = '0;
                best_next = '0;
                res_next = '0;
            end
            ST_SCAN, ST_SCAN_LAST:
            begin
                rd_addr = cnt_idx;
                cnt_next = cnt_reg + (SLOT_W + 1)'(1);
                if (scan_take)
                begin
                    found_next = 1'b1;
                    best_next = SLOT_W'(cnt_reg - (SLOT_W + 1)'(1));
                    late_next = scan_late;
                end
            end
            ST_READ:
            begin
                due_next = rd_due;
                act_next = rd_act;
                idn_next = rd_ident;
                if (cmd_reg.func == FUNC_UPDATE)
                begin
                    rank_use_next = {1'b0, (cmd_reg.slot == SLOT_W'(0)) ? RANK_W'(0)
                                                                        : rank_reg};
                    if (cmd_reg.slot_identity != rd_ident)
                    begin
                        res_next.clear_usage = 1'b1;
                        res_next.clear_token = (rd_ident != 32'd0);
                    end
                    quo_next = period_reg;
                    rem_next = '0;
                    cnt_next = '0;
                    fcnt_next = 16'd31;
                end
                else if (cmd_reg.slot_identity != rd_ident)
                    res_next.discarded = 1'b1;
                else
                begin
                    case (cmd_reg.error_code)
                        ERR_OK:
                            due_next = rd_due + period_reg;
                        ERR_AUTH, ERR_RELOGIN:
                            due_next = cmd_reg.now_ms + auth_reg;
                        ERR_REFRESH:
                            due_next = cmd_reg.now_ms + refresh_reg;
                        ERR_PARSER:
                            due_next = cmd_reg.now_ms + parser_reg;
                        ERR_NOCONF:
                            due_next = cmd_reg.now_ms + period_reg;
                        default: ;
                    endcase
                    wait_next = {1'b0, period_reg};
                    fcnt_next = cmd_reg.failures;
                end
            end
            ST_DIV:
            begin
                // restoring divide, one quotient bit a cycle
                if (!div_trial[32])
                begin
                    rem_next = div_trial;
                    quo_next = {quo_reg[30:0], 1'b1};
                end
                else
                begin
                    rem_next = {rem_reg[31:0], quo_reg[31]};
                    quo_next = {quo_reg[30:0], 1'b0};
                end
                fcnt_next = fcnt_reg - 16'd1;
                if (cmd_reg.active_total == 4'd0)
                    quo_next = '0;
            end
            ST_MUL:
                due_next = cmd_reg.now_ms + GRID_LEAD_MS + grid_off;
            ST_DBL:
                if (fcnt_reg > 16'd1 && wait_reg < {1'b0, boffmax_reg} && wait_reg != 33'd0)
                begin
                    wait_next = {wait_reg[31:0], 1'b0};
                    fcnt_next = fcnt_reg - 16'd1;
                end
            ST_RETRY:
            begin
                if (wait_reg > {1'b0, boffmax_reg})
                    wait_next = {1'b0, boffmax_reg};
                if (cmd_reg.error_code == ERR_RATE && cmd_reg.retry_after_s != 32'd0 &&
                    {1'b0, retry_ms} > ((wait_reg > {1'b0, boffmax_reg}) ?
                                        {1'b0, boffmax_reg} : wait_reg))
                    wait_next = {1'b0, retry_ms};
            end
            ST_WRITE:
            begin
                if (cmd_reg.func == FUNC_UPDATE)
                begin
                    mem_we = 1'b1;
                    wr_data = {due_reg, cmd_reg.now_active, cmd_reg.slot_identity};
                    rank_next = rank_use_reg[3:0];
                    if (cmd_reg.now_active && rank_use_reg[3:0] < RANK_MAX)
                        rank_next = rank_use_reg[3:0] + 4'd1;
                    res_next.next_due_ms = due_reg;
                end
                else if (res_reg.discarded)
                    res_next.next_due_ms = due_reg;
                else
                begin
                    mem_we = 1'b1;
                    if (cmd_reg.error_code == ERR_OK)
                    begin
                        if (!ok_diff[31])
                            due_next = cmd_reg.now_ms + period_reg;
                        else
                            due_next = ok_due;
                    end
                    else if (cmd_reg.error_code >= ERR_RATE)
                        due_next = cmd_reg.now_ms + wait_reg[31:0];
                    wr_data = {due_next, act_reg, idn_reg};
                    res_next.next_due_ms = due_next;
                end
            end
            ST_DONE:
            begin
                done_next = 1'b1;
                if (cmd_reg.func == FUNC_TICK && found_reg)
                begin
                    res_next.picked = 1'b1;
                    res_next.picked_slot = best_reg;
                    res_next.lateness_ms = late_reg[30:0];
                end
            end
            default: ;
        endcase
    end

    // ok completion keeps the original due time in due_reg for the catch-up compare
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            rank_reg <= '0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
            found_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            rank_reg <= rank_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
            found_reg <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && start)
            cmd_reg <= cmd;
        best_reg <= best_next;
        late_reg <= late_next;
        due_reg <= (state_reg == ST_READ && cmd_reg.error_code == ERR_OK &&
                    cmd_reg.func == FUNC_DONE) ? rd_due : due_next;
        act_reg <= act_next;
        idn_reg <= idn_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        wait_reg <= wait_next;
        fcnt_reg <= fcnt_next;
        rank_use_reg <= rank_use_next;
        res_reg <= res_next;
    end

    always_comb
    begin
        busy = (state_reg != ST_IDLE);
        done = done_reg;
        result = res_reg;
    end

    `DSS_ASSERT_IMPL(a_done_idle, done, state_reg == ST_IDLE)
    `DSS_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
    `DSS_ASSERT_IMPL(a_write_state, mem_we, state_reg == ST_WRITE)
endmodule
